// File: hdl/assert_macros.svh
// Assertion macros used by the checker file mmrsg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_HOLD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/mmrsg_pkg.sv
// Types, constants and helper functions of the random sample generator.
package mmrsg_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_GEN     = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Sample modes.
  localparam logic [1:0] MODE_UNIFORM = 2'd0;
  localparam logic [1:0] MODE_BERN32  = 2'd1;
  localparam logic [1:0] MODE_BERN16  = 2'd2;
  localparam logic [1:0] MODE_GAUSS   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SEED_LOW  = 3'd0;
  localparam logic [2:0] REG_SEED_HIGH = 3'd1;
  localparam logic [2:0] REG_MODE      = 3'd2;
  localparam logic [2:0] REG_RANGE     = 3'd3;
  localparam logic [2:0] REG_OFFSET    = 3'd4;
  localparam logic [2:0] REG_THRESHOLD = 3'd5;

  localparam logic [2:0]  LANES_WIDE   = 3'd2;
  localparam logic [2:0]  LANES_NARROW = 3'd4;
  localparam logic [31:0] GAUSS_BIAS   = 32'd186;

  typedef enum logic [1:0] {
    OP_RESTART,
    OP_GEN,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] n;
  } cmd_t;

  typedef struct packed {
    logic [63:0] seed_low;
    logic [63:0] seed_high;
    logic [1:0]  mode;
    logic [31:0] range_mul;
    logic [31:0] offset;
    logic [32:0] threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WARM,
    BK_READ,
    BK_GEN
  } back_state_t;

  // Sum of the twelve low 5-bit fields of a draw.
  function automatic logic [8:0] gauss_sum(input logic [63:0] r);
    gauss_sum = 9'(r[4:0])   + 9'(r[9:5])   + 9'(r[14:10]) + 9'(r[19:15])
              + 9'(r[24:20]) + 9'(r[29:25]) + 9'(r[34:30]) + 9'(r[39:35])
              + 9'(r[44:40]) + 9'(r[49:45]) + 9'(r[54:50]) + 9'(r[59:55]);
  endfunction

endpackage

// File: hdl/multi_mode_random_sample_generator.sv
// Random sample generator on a xoroshiro128+ core with uniform, Bernoulli and Gaussian modes.
//
// Channels: the input stream carries one command per item (kind on in_tuser, count in
// in_tdata); the result stream carries sample and state word on out_tdata with out_tlast
// marking the final result of a command; the cfg channel writes the six registers and is
// always ready. The user must write registers only while no command is in flight; the
// block does not enforce it. A restart item reloads the state from the seeds and steps it
// WARMUP_STEPS times, a read item returns the two state words, a generate item returns up to
// count samples. The first result of a generate or read item, when the back end is idle,
// passes the command queue, the back end's decode and the output register to out_tdata.
// The single generator step unit and the one output register set the pace; the back end
// takes a new command only once the last is done. A generate item takes its samples from one
// draw, save in Gaussian mode, which always draws four times.
// A two-entry command queue lets the input accept further items while the back end works.
// Reset clears the state words, the six configuration registers and the queue; no result is pending after it.
// When the receiver stalls, the held result stays on out_tdata, the back end waits and the
// input keeps taking items until the queue is full.
module multi_mode_random_sample_generator #(
  parameter int WARMUP_STEPS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mmrsg_pkg::IN_TDATA_W-1:0]  in_tdata,   // [2:0] count, rest zero
  input  logic [mmrsg_pkg::IN_TUSER_W-1:0]  in_tuser,   // [1:0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mmrsg_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] sample, [95:32] state_word
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmrsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmrsg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mmrsg_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic q_push, q_pop, q_empty, q_full;

  mmrsg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mmrsg_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .mode      (cfg.mode),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mmrsg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  mmrsg_back #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/mmrsg_cfg.sv
// Configuration register file written through the cfg channel.
module mmrsg_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mmrsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmrsg_pkg::CFG_DATA_W-1:0] cfg_data,
  output mmrsg_pkg::cfg_t                  cfg
);
  import mmrsg_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEED_LOW:  cfg_r.seed_low  <= cfg_data;
        REG_SEED_HIGH: cfg_r.seed_high <= cfg_data;
        REG_MODE:      cfg_r.mode      <= cfg_data[1:0];
        REG_RANGE:     cfg_r.range_mul <= cfg_data[31:0];
        REG_OFFSET:    cfg_r.offset    <= cfg_data[31:0];
        REG_THRESHOLD: cfg_r.threshold <= cfg_data[32:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/mmrsg_front.sv
// Front end: accepts input items and turns them into queued commands.
module mmrsg_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mmrsg_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [mmrsg_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic [1:0]                       mode,
  input  logic                             q_full,
  output logic                             q_push,
  output mmrsg_pkg::cmd_t                  q_cmd
);
  import mmrsg_pkg::*;

  logic [2:0] count;
  logic [2:0] lanes;
  logic       keep;

  assign count     = in_tdata[2:0];
  assign in_tready = !q_full;
  assign lanes     = (mode == MODE_BERN16 || mode == MODE_GAUSS) ? LANES_NARROW : LANES_WIDE;

  always_comb begin
    keep     = 1'b0;
    q_cmd.op = OP_GEN;
    q_cmd.n  = (count > lanes) ? lanes : count;
    unique case (in_tuser)
      KIND_RESTART: begin
        keep     = 1'b1;
        q_cmd.op = OP_RESTART;
      end
      KIND_GEN: begin
        // A generate item asking for nothing leaves no trace.
        keep     = (count != 3'd0);
        q_cmd.op = OP_GEN;
      end
      KIND_READ: begin
        keep     = 1'b1;
        q_cmd.op = OP_READ;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_tvalid && !q_full && keep;

endmodule

// File: hdl/mmrsg_queue.sv
// Short command queue between the front end and the generator back end.
module mmrsg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mmrsg_pkg::cmd_t push_cmd,
  input  logic            pop,
  output mmrsg_pkg::cmd_t head_cmd,
  output logic            empty,
  output logic            full
);
  import mmrsg_pkg::*;

  cmd_t               q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign head_cmd = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (Q_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (Q_PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: hdl/mmrsg_back.sv
// Back end: xoroshiro128+ state, lane shaping and the output register.
module mmrsg_back #(
  parameter int WARMUP_STEPS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mmrsg_pkg::cfg_t                   cfg,
  input  logic                              q_empty,
  input  mmrsg_pkg::cmd_t                   q_cmd,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mmrsg_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast
);
  import mmrsg_pkg::*;

  localparam int WW = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

  back_state_t st_r, st_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [2:0]    n_r, n_nxt;
  logic [63:0]   word_a_r, word_a_nxt;
  logic [63:0]   word_b_r, word_b_nxt;
  logic [63:0]   draw_r, draw_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_sample_r, out_sample_nxt;
  logic [63:0]   out_word_r, out_word_nxt;
  logic          out_last_r, out_last_nxt;

  logic [63:0] t_mix, step_a, step_b;
  logic        can_emit, do_step, need_emit, is_gauss, done;
  logic [31:0] lane32, lane_sample, scaled;
  logic [15:0] lane16;
  logic [63:0] prod;

  // One generator step: t = a ^ b, a' = rotl(a,55) ^ t ^ (t << 14), b' = rotl(t,36).
  assign t_mix  = word_a_r ^ word_b_r;
  assign step_a = {word_a_r[8:0], word_a_r[63:9]} ^ t_mix ^ (t_mix << 14);
  assign step_b = {t_mix[27:0], t_mix[63:28]};

  assign lane32 = k_r[0] ? draw_r[63:32] : draw_r[31:0];
  assign prod   = 64'(lane32) * 64'(cfg.range_mul);
  assign scaled = (cfg.range_mul == '0) ? lane32 : prod[63:32];
  assign is_gauss = (cfg.mode == MODE_GAUSS);

  always_comb begin
    unique case (k_r)
      2'd0: lane16 = draw_r[15:0];
      2'd1: lane16 = draw_r[31:16];
      2'd2: lane16 = draw_r[47:32];
      2'd3: lane16 = draw_r[63:48];
    endcase
  end

  always_comb begin
    unique case (cfg.mode)
      MODE_UNIFORM: lane_sample = scaled + cfg.offset;
      MODE_BERN32:  lane_sample = 32'({1'b0, lane32} < cfg.threshold);
      MODE_BERN16:  lane_sample = 32'({17'b0, lane16} < cfg.threshold);
      MODE_GAUSS:   lane_sample = 32'(gauss_sum(draw_r)) - GAUSS_BIAS;
    endcase
  end

  assign can_emit  = !out_valid_r || out_tready;
  assign need_emit = ({1'b0, k_r} < n_r);

  always_comb begin
    st_nxt         = st_r;
    k_nxt          = k_r;
    w_nxt          = w_r;
    n_nxt          = n_r;
    word_a_nxt     = word_a_r;
    word_b_nxt     = word_b_r;
    draw_nxt       = draw_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sample_nxt = out_sample_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    do_step        = 1'b0;
    done           = 1'b0;

    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            OP_RESTART: begin
              word_a_nxt = cfg.seed_low;
              word_b_nxt = cfg.seed_high;
              w_nxt      = '0;
              if (WARMUP_STEPS > 0) begin
                st_nxt = BK_WARM;
              end
            end
            OP_READ: begin
              k_nxt  = '0;
              st_nxt = BK_READ;
            end
            OP_GEN: begin
              // The first draw is taken while the command is decoded.
              do_step = 1'b1;
              k_nxt   = '0;
              n_nxt   = q_cmd.n;
              st_nxt  = BK_GEN;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_WARM: begin
        do_step = 1'b1;
        w_nxt   = w_r + WW'(1);
        if (w_r == WW'(WARMUP_STEPS - 1)) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_READ: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = '0;
          out_word_nxt   = k_r[0] ? word_b_r : word_a_r;
          out_last_nxt   = k_r[0];
          k_nxt          = k_r + 2'd1;
          if (k_r[0]) begin
            st_nxt = BK_IDLE;
          end
        end
      end
      BK_GEN: begin
        if (!need_emit || can_emit) begin
          if (need_emit) begin
            out_valid_nxt  = 1'b1;
            out_sample_nxt = lane_sample;
            out_word_nxt   = '0;
            out_last_nxt   = ({1'b0, k_r} == n_r - 3'd1);
          end
          // Gaussian samples always consume four draws, whatever the count.
          do_step = is_gauss && (k_r != 2'd3);
          done    = is_gauss ? (k_r == 2'd3) : ({1'b0, k_r} == n_r - 3'd1);
          k_nxt   = k_r + 2'd1;
          if (done) begin
            st_nxt = BK_IDLE;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase

    if (do_step) begin
      word_a_nxt = step_a;
      word_b_nxt = step_b;
      draw_nxt   = word_a_r + word_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      k_r         <= '0;
      w_r         <= '0;
      n_r         <= '0;
      word_a_r    <= '0;
      word_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      k_r         <= k_nxt;
      w_r         <= w_nxt;
      n_r         <= n_nxt;
      word_a_r    <= word_a_nxt;
      word_b_r    <= word_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    draw_r       <= draw_nxt;
    out_sample_r <= out_sample_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_word_r, out_sample_r};
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/mmrsg_checker.sv
// Port-level checks on the random sample generator, bound to the top level.
`include "assert_macros.svh"

module mmrsg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mmrsg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast
);

  // A stalled result holds its contents.
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
            out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Only read results carry a state word, and their sample is zero.
  `CHK_HOLD(a_word_only_on_read, clk, rst_n,
            !(out_tvalid && out_tdata[95:32] != 64'd0) || out_tdata[31:0] == 32'd0)

  // Reset leaves nothing pending and the input ready.
  `CHK_NEXT(a_reset_clear, clk, 1'b1, !rst_n, !out_tvalid && in_tready)

endmodule

bind multi_mode_random_sample_generator mmrsg_checker u_mmrsg_checker (.*);

// File: bench/tb.sv
// Self-checking testbench for the multi-mode random sample generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmrsg_pkg::*;

  localparam int WARMUP      = 4;
  localparam int SETTLE      = 24;
  localparam int RANDOM_ITEMS = 185;

  // Codes the package leaves out: the unused command kind and the spare register slots.
  localparam logic [1:0] KIND_NONE     = 2'd3;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [31:0] sample;
    logic [63:0] word;
    logic        last;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_e;

  typedef struct packed {
    row_e        what;
    logic [2:0]  reg_idx;
    logic [63:0] value;
    logic [1:0]  kind;
    logic [2:0]  count;
    logic        known;
    logic [2:0]  n_res;
    logic [31:0] res_sample;
  } stim_row_t;

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [63:0] val);
    return '{ROW_CFG, idx, val, KIND_RESTART, 3'd0, 1'b0, 3'd0, 32'd0};
  endfunction

  function automatic stim_row_t cmd_row(logic [1:0] kind, logic [2:0] cnt);
    return '{ROW_ITEM, REG_SEED_LOW, 64'd0, kind, cnt, 1'b0, 3'd0, 32'd0};
  endfunction

  // Item whose results are all the same sample with a zero state word.
  function automatic stim_row_t known_row(logic [1:0] kind, logic [2:0] cnt,
                                          logic [2:0] n, logic [31:0] smp);
    return '{ROW_ITEM, REG_SEED_LOW, 64'd0, kind, cnt, 1'b1, n, smp};
  endfunction

  localparam int N_ROWS = 39;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // A zero state stays zero, so reads and uniform draws give zeros after reset.
    known_row(KIND_READ, 3'd0, 3'd2, 32'd0),
    known_row(KIND_GEN, 3'd2, 3'd2, 32'd0),
    cfg_row(REG_SEED_LOW, 64'hFFFF_FFFF_FFFF_FFFF),
    cfg_row(REG_SEED_HIGH, 64'h0123_4567_89AB_CDEF),
    known_row(KIND_RESTART, 3'd0, 3'd0, 32'd0),
    cmd_row(KIND_READ, 3'd5),
    cmd_row(KIND_GEN, 3'd1),
    cmd_row(KIND_GEN, 3'd4),
    cmd_row(KIND_GEN, 3'd7),
    cfg_row(REG_RANGE, 64'h0000_0000_FFFF_FFFF),
    cfg_row(REG_OFFSET, 64'h0000_0000_8000_0000),
    cmd_row(KIND_GEN, 3'd2),
    // A range of one scales every lane to zero, leaving the offset alone.
    cfg_row(REG_RANGE, 64'd1),
    cfg_row(REG_OFFSET, 64'h0000_0000_7FFF_FFFF),
    known_row(KIND_GEN, 3'd2, 3'd2, 32'h7FFF_FFFF),
    known_row(KIND_GEN, 3'd0, 3'd0, 32'd0),
    known_row(KIND_NONE, 3'd7, 3'd0, 32'd0),
    cfg_row(REG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF),
    cfg_row(REG_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF),
    cfg_row(REG_MODE, 64'(MODE_BERN32)),
    cfg_row(REG_THRESHOLD, 64'd0),
    known_row(KIND_GEN, 3'd3, 3'd2, 32'd0),
    cfg_row(REG_THRESHOLD, 64'h1_0000_0000),
    known_row(KIND_GEN, 3'd2, 3'd2, 32'd1),
    cfg_row(REG_MODE, 64'(MODE_BERN16)),
    known_row(KIND_GEN, 3'd5, 3'd4, 32'd1),
    cfg_row(REG_THRESHOLD, 64'h8000),
    cmd_row(KIND_GEN, 3'd4),
    cmd_row(KIND_GEN, 3'd1),
    cfg_row(REG_MODE, 64'(MODE_GAUSS)),
    cmd_row(KIND_GEN, 3'd1),
    cmd_row(KIND_GEN, 3'd4),
    cmd_row(KIND_GEN, 3'd6),
    cfg_row(REG_SEED_LOW, 64'd0),
    cfg_row(REG_SEED_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
    cmd_row(KIND_RESTART, 3'd3),
    cmd_row(KIND_READ, 3'd0),
    cfg_row(REG_MODE, 64'(MODE_UNIFORM)),
    cmd_row(KIND_GEN, 3'd2)
  };

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  multi_mode_random_sample_generator #(.WARMUP_STEPS(WARMUP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Own copy of the generator state and the register file.
  logic [63:0] st_a = '0, st_b = '0;
  logic [63:0] seed_lo_q = '0, seed_hi_q = '0;
  logic [1:0]  mode_q = MODE_UNIFORM;
  logic [31:0] range_q = '0, offset_q = '0;
  logic [32:0] thresh_q = '0;

  result_t pending_results[$];
  int      mismatches = 0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;
  int      stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One xoroshiro128+ step: returns the sum and moves the state on.
  function automatic logic [63:0] xoro_step();
    logic [63:0] t, sum;
    sum  = st_a + st_b;
    t    = st_a ^ st_b;
    st_a = {st_a[8:0], st_a[63:9]} ^ t ^ (t << 14);
    st_b = {t[27:0], t[63:28]};
    return sum;
  endfunction

  task automatic predict_samples(input logic [1:0] kind, input logic [2:0] cnt,
                                 input bit record);
    logic [63:0] draw_v;
    logic [63:0] prod;
    logic [31:0] lane_v [4];
    logic [31:0] lane;
    logic [31:0] acc;
    int          lanes, n;
    lanes = 0;
    case (kind)
      KIND_RESTART: begin
        st_a = seed_lo_q;
        st_b = seed_hi_q;
        repeat (WARMUP) draw_v = xoro_step();
      end
      KIND_READ: begin
        if (record) begin
          pending_results.push_back(result_t'{32'd0, st_a, 1'b0});
          pending_results.push_back(result_t'{32'd0, st_b, 1'b1});
        end
      end
      KIND_GEN: begin
        if (cnt != 3'd0) begin
          if (mode_q == MODE_GAUSS) begin
            // Four draws even when fewer samples are wanted.
            for (int k = 0; k < 4; k++) begin
              draw_v = xoro_step();
              acc = '0;
              for (int j = 0; j < 12; j++) acc += 32'(draw_v[5*j +: 5]);
              lane_v[k] = acc - GAUSS_BIAS;
            end
            lanes = int'(LANES_NARROW);
          end else if (mode_q == MODE_BERN16) begin
            draw_v = xoro_step();
            for (int k = 0; k < 4; k++)
              lane_v[k] = (33'(draw_v[16*k +: 16]) < thresh_q) ? 32'd1 : 32'd0;
            lanes = int'(LANES_NARROW);
          end else begin
            draw_v = xoro_step();
            for (int k = 0; k < 2; k++) begin
              lane = draw_v[32*k +: 32];
              if (mode_q == MODE_BERN32) begin
                lane_v[k] = (33'(lane) < thresh_q) ? 32'd1 : 32'd0;
              end else begin
                if (range_q != '0) begin
                  prod = 64'(lane) * 64'(range_q);
                  lane = prod[63:32];
                end
                lane_v[k] = lane + offset_q;
              end
            end
            lanes = int'(LANES_WIDE);
          end
          n = (int'(cnt) < lanes) ? int'(cnt) : lanes;
          if (record)
            for (int k = 0; k < n; k++)
              pending_results.push_back(result_t'{lane_v[k], 64'd0, k == n - 1});
        end
      end
      default: ;
    endcase
  endtask

  // Stop sending, let every expected result arrive, then allow the block to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SEED_LOW:  seed_lo_q = val;
      REG_SEED_HIGH: seed_hi_q = val;
      REG_MODE:      mode_q    = val[1:0];
      REG_RANGE:     range_q   = val[31:0];
      REG_OFFSET:    offset_q  = val[31:0];
      REG_THRESHOLD: thresh_q  = val[32:0];
      default: ;
    endcase
  endtask

  // Returns at the edge where the item is taken.
  task automatic send_item(input logic [1:0] kind, input logic [2:0] cnt);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_TDATA_W'(cnt);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_value(logic [2:0] idx);
    case (idx)
      REG_SEED_LOW, REG_SEED_HIGH: begin
        case ($urandom_range(0, 7))
          0: return '0;
          1: return '1;
          default: return {$urandom, $urandom};
        endcase
      end
      REG_MODE: return 64'($urandom_range(0, 3));
      REG_RANGE: begin
        case ($urandom_range(0, 5))
          0: return 64'd0;
          1: return 64'd1;
          2: return 64'hFFFF_FFFF;
          default: return 64'($urandom);
        endcase
      end
      REG_OFFSET: begin
        case ($urandom_range(0, 5))
          0: return 64'h8000_0000;
          1: return 64'h7FFF_FFFF;
          default: return 64'($urandom);
        endcase
      end
      REG_THRESHOLD: begin
        case ($urandom_range(0, 5))
          0: return 64'd0;
          1: return 64'h1_0000_0000;
          2: return 64'h1_0000;
          3: return {47'd0, 1'($urandom_range(0, 1)), 16'($urandom)};
          default: return {31'd0, 1'($urandom_range(0, 1)), $urandom};
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiver: random stalls, short mostly, with calm stretches in between.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 2) == 0) begin
      stall_left <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'{out_tdata[31:0], out_tdata[95:32], out_tlast};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sample %h word %h last %b",
                   got.sample, got.word, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.sample !== want.sample || got.word !== want.word ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want sample %h word %h last %b, got sample %h word %h last %b",
                     want.sample, want.word, want.last, got.sample, got.word, got.last);
        end
      end
    end
  end

  initial begin
    stim_row_t   row;
    int          items_done;
    int          pick;
    logic [1:0]  k;
    logic [2:0]  c;
    items_done = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.what == ROW_CFG) begin
        write_reg(row.reg_idx, row.value);
      end else begin
        send_item(row.kind, row.count);
        predict_samples(row.kind, row.count, !row.known);
        if (row.known)
          for (int r = 0; r < int'(row.n_res); r++)
            pending_results.push_back(result_t'{row.res_sample, 64'd0,
                                                r == int'(row.n_res) - 1});
      end
    end

    while (items_done < RANDOM_ITEMS) begin
      for (int r = 0; r < 6; r++)
        if ($urandom_range(0, 2) != 0) write_reg(3'(r), rand_value(3'(r)));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, {$urandom, $urandom});
      tx_steady = ($urandom_range(0, 3) == 0);
      c = 3'($urandom);
      send_item(KIND_RESTART, c);
      predict_samples(KIND_RESTART, c, 1'b1);
      items_done++;
      repeat ($urandom_range(12, 36)) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          k = KIND_GEN;
          c = 3'($urandom_range(1, 4));
        end else if (pick < 78) begin
          k = KIND_READ;
          c = 3'($urandom);
        end else if (pick < 83) begin
          k = KIND_RESTART;
          c = 3'($urandom);
        end else if (pick < 90) begin
          k = KIND_GEN;
          c = 3'($urandom_range(5, 7));
        end else if (pick < 95) begin
          k = KIND_GEN;
          c = 3'd0;
        end else begin
          k = KIND_NONE;
          c = 3'($urandom);
        end
        send_item(k, c);
        predict_samples(k, c, 1'b1);
        items_done++;
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mmrsg_pkg.sv
hdl/mmrsg_cfg.sv
hdl/mmrsg_front.sv
hdl/mmrsg_queue.sv
hdl/mmrsg_back.sv
hdl/multi_mode_random_sample_generator.sv
hdl/mmrsg_checker.sv
bench/tb.sv
